// ===== rtl/wall_column_projection_macros.svh =====
// Assertion macros shared by the wall column projection RTL.
`ifndef WALL_COLUMN_PROJECTION_MACROS_SVH
`define WALL_COLUMN_PROJECTION_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define WCP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wall column projection check failed");

// Next-cycle implication checked outside reset.
`define WCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wall column projection check failed");

`endif

// ===== rtl/wcp_pkg.sv =====
// Shared constants and types for the wall column projection block.
`timescale 1ns / 1ps
package wcp_pkg;

    localparam logic [1:0] SIGN_POS = 2'd1;
    localparam logic [1:0] SIGN_NEG = 2'd2;

    localparam logic [1:0] FACE_EAST  = 2'd0;
    localparam logic [1:0] FACE_WEST  = 2'd1;
    localparam logic [1:0] FACE_SOUTH = 2'd2;
    localparam logic [1:0] FACE_NORTH = 2'd3;

    localparam logic [1:0] REG_NEAR_LIMIT     = 2'd0;
    localparam logic [1:0] REG_TEXTURE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_TEXTURE_HEIGHT = 2'd2;

    localparam int DIST_W   = 24;
    localparam int FRAC_W   = 16;
    localparam int TEX_W    = 11;
    localparam int HEIGHT_W = 19;
    localparam int ROW_W    = 10;
    localparam int COL_W    = 10;
    localparam int Q26_W    = 26;

    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = {HEIGHT_W{1'b1}};
    localparam logic [Q26_W-1:0]    Q26_MAX    = {Q26_W{1'b1}};
    localparam logic [COL_W-1:0]    COL_MAX    = {COL_W{1'b1}};

    // Side information that rides alongside the divider pipelines.
    typedef struct packed {
        logic [COL_W-1:0] texel_column;
        logic [1:0]       wall_face;
        logic [TEX_W-1:0] texture_height;
    } side_info_t;

endpackage

// ===== rtl/wcp_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module wcp_divider #(
    parameter int NUM_W  = 34,
    parameter int DEN_W  = 24,
    parameter int TAG_W  = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] numerator,
    input  logic [DEN_W-1:0] denominator,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [NUM_W-1:0] quotient,
    output logic [TAG_W-1:0] out_tag
);
    // Remainder needs one bit more than the divisor for the trial subtract.
    localparam int REM_W = DEN_W + 1;

    logic             valid_reg [NUM_W+1];
    logic [NUM_W-1:0] num_reg   [NUM_W+1];
    logic [NUM_W-1:0] quo_reg   [NUM_W+1];
    logic [REM_W-1:0] rem_reg   [NUM_W+1];
    logic [DEN_W-1:0] den_reg   [NUM_W+1];
    logic [TAG_W-1:0] tag_reg   [NUM_W+1];

    always_comb
    begin
        valid_reg[0] = in_valid;
        num_reg[0]   = numerator;
        quo_reg[0]   = '0;
        rem_reg[0]   = '0;
        den_reg[0]   = denominator;
        tag_reg[0]   = in_tag;
    end

    for (genvar s = 0; s < NUM_W; s++)
    begin : g_stage
        logic [REM_W-1:0] shifted;
        logic [REM_W:0]   trial;
        assign shifted = {rem_reg[s][REM_W-2:0], num_reg[s][NUM_W-1-s]};
        assign trial   = {1'b0, shifted} - {2'b00, den_reg[s]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s+1] <= 1'b0;
            end
            else
            begin
                valid_reg[s+1] <= valid_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            num_reg[s+1] <= num_reg[s];
            den_reg[s+1] <= den_reg[s];
            tag_reg[s+1] <= tag_reg[s];
            if (!trial[REM_W])
            begin
                rem_reg[s+1] <= trial[REM_W-1:0];
                quo_reg[s+1] <= quo_reg[s] | ({{(NUM_W-1){1'b0}}, 1'b1} << (NUM_W-1-s));
            end
            else
            begin
                rem_reg[s+1] <= shifted;
                quo_reg[s+1] <= quo_reg[s];
            end
        end
    end

    assign out_valid = valid_reg[NUM_W];
    assign quotient  = quo_reg[NUM_W];
    assign out_tag   = tag_reg[NUM_W];

endmodule

// ===== rtl/wall_column_projection.sv =====
// Top level of the raycaster wall column projection pipeline.
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------
//  request   | start / busy       | wall_distance, hit_fraction, hit_side,
//            |                    | dir_x_sign, dir_y_sign
//  result    | done (one cycle)   | wall_height, top_row, bottom_row,
//            |                    | wall_face, texel_column, row_step, row_start
//  config    | cfg_we             | cfg_index, cfg_data
//
// One request enters per clock; busy is tied low. A request passes through the
// input stage, the height divider, stage 2, the row step divider (each divider
// has one stage per quotient bit), then stages 3 and 4. Reset clears all valid
// bits and loads the register defaults; payload flops are not reset. The receiver
// cannot stall, so results leave on done without backpressure.
`timescale 1ns / 1ps
`include "wall_column_projection_macros.svh"
module wall_column_projection #(
    parameter int SCREEN_ROWS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [wcp_pkg::DIST_W-1:0]   wall_distance,
    input  logic [wcp_pkg::FRAC_W-1:0]   hit_fraction,
    input  logic                         hit_side,
    input  logic [1:0]                   dir_x_sign,
    input  logic [1:0]                   dir_y_sign,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [wcp_pkg::DIST_W-1:0]   cfg_data,
    output logic                         done,
    output logic [wcp_pkg::HEIGHT_W-1:0] wall_height,
    output logic [wcp_pkg::ROW_W-1:0]    top_row,
    output logic [wcp_pkg::ROW_W-1:0]    bottom_row,
    output logic [1:0]                   wall_face,
    output logic [wcp_pkg::COL_W-1:0]    texel_column,
    output logic [wcp_pkg::Q26_W-1:0]    row_step,
    output logic [wcp_pkg::Q26_W-1:0]    row_start
);
    import wcp_pkg::*;

    // Numerator SCREEN_ROWS << 16 needs the row count width plus 16.
    localparam int RW      = $clog2(SCREEN_ROWS + 1);
    localparam int HNUM_W  = RW + 16;
    localparam int SNUM_W  = TEX_W + 16;
    localparam int INFO_W  = $bits(side_info_t);
    localparam logic [RW-1:0] ROWS   = RW'(SCREEN_ROWS);
    localparam logic [RW-1:0] CENTER = RW'(SCREEN_ROWS / 2);
    localparam logic [RW-1:0] LAST   = RW'(SCREEN_ROWS - 1);

    // Configuration registers.
    logic [DIST_W-1:0] near_limit_reg;
    logic [TEX_W-1:0]  texture_width_reg;
    logic [TEX_W-1:0]  texture_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_limit_reg     <= DIST_W'(6554);
            texture_width_reg  <= TEX_W'(64);
            texture_height_reg <= TEX_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NEAR_LIMIT:     near_limit_reg     <= cfg_data;
                REG_TEXTURE_WIDTH:  texture_width_reg  <= cfg_data[TEX_W-1:0];
                REG_TEXTURE_HEIGHT: texture_height_reg <= cfg_data[TEX_W-1:0];
                default:            ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 1: clamp the distance, pick the face, scale the texture column.
    logic              s1_valid_reg;
    logic [DIST_W-1:0] s1_dist_reg;
    side_info_t        s1_info_reg;

    logic [DIST_W-1:0]        dist_clamped;
    logic [FRAC_W+TEX_W-1:0]  col_product;
    logic [TEX_W-1:0]         col_raw;
    logic [TEX_W-1:0]         col_lim;
    logic [TEX_W-1:0]         col_sel;
    logic [TEX_W-1:0]         col_fin;
    logic                     mirror;
    logic [1:0]               face_next;

    always_comb
    begin
        dist_clamped = (wall_distance < near_limit_reg) ? near_limit_reg : wall_distance;
        if (dist_clamped == '0)
        begin
            dist_clamped = DIST_W'(1);
        end
        if (!hit_side)
        begin
            face_next = (dir_x_sign == SIGN_NEG) ? FACE_EAST : FACE_WEST;
        end
        else
        begin
            face_next = (dir_y_sign == SIGN_NEG) ? FACE_SOUTH : FACE_NORTH;
        end
        mirror = (!hit_side && dir_x_sign == SIGN_POS) || (hit_side && dir_y_sign == SIGN_NEG);
        col_product = {{TEX_W{1'b0}}, hit_fraction} * {{FRAC_W{1'b0}}, texture_width_reg};
        col_raw = col_product[FRAC_W+TEX_W-1:FRAC_W];
        col_lim = texture_width_reg - TEX_W'(1);
        // Mirror may wrap below zero; the clamp below catches it.
        col_sel = mirror ? (col_lim - col_raw) : col_raw;
        col_fin = (col_sel > col_lim) ? col_lim : col_sel;
        if (texture_width_reg == '0)
        begin
            col_fin = '0;
        end
        else if (col_fin > TEX_W'(COL_MAX))
        begin
            col_fin = TEX_W'(COL_MAX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dist_reg                <= dist_clamped;
        s1_info_reg.texel_column   <= col_fin[COL_W-1:0];
        s1_info_reg.wall_face      <= face_next;
        s1_info_reg.texture_height <= texture_height_reg;
    end

    // Height divider: (SCREEN_ROWS << 16) / distance.
    logic              hd_valid;
    logic [HNUM_W-1:0] hd_quo;
    logic [INFO_W-1:0] hd_tag;

    wcp_divider #(
        .NUM_W(HNUM_W),
        .DEN_W(DIST_W),
        .TAG_W(INFO_W)
    ) u_height_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid_reg),
        .numerator  ({ROWS, 16'd0}),
        .denominator(s1_dist_reg),
        .in_tag     (s1_info_reg),
        .out_valid  (hd_valid),
        .quotient   (hd_quo),
        .out_tag    (hd_tag)
    );

    // Stage 2: bound the height and derive the drawn rows.
    logic                s2_valid_reg;
    logic [HEIGHT_W-1:0] s2_height_reg;
    logic [ROW_W-1:0]    s2_top_reg;
    logic [ROW_W-1:0]    s2_bottom_reg;
    side_info_t          s2_info_reg;

    logic [HEIGHT_W-1:0] h_next;
    logic [HEIGHT_W-1:0] half;
    logic [HEIGHT_W:0]   bot_sum;
    logic [HEIGHT_W:0]   top_val;
    logic [HEIGHT_W:0]   bot_val;

    always_comb
    begin
        if (hd_quo == '0)
        begin
            h_next = HEIGHT_W'(1);
        end
        else if ({{HEIGHT_W{1'b0}}, hd_quo} > {{HNUM_W{1'b0}}, HEIGHT_MAX})
        begin
            h_next = HEIGHT_MAX;
        end
        else
        begin
            h_next = hd_quo[HEIGHT_W-1:0];
        end
        half    = h_next >> 1;
        top_val = ({1'b0, half} >= (HEIGHT_W+1)'(CENTER)) ? '0
                  : (HEIGHT_W+1)'(CENTER) - {1'b0, half};
        bot_sum = (HEIGHT_W+1)'(CENTER) + {1'b0, half};
        bot_val = (bot_sum > (HEIGHT_W+1)'(LAST)) ? (HEIGHT_W+1)'(LAST) : bot_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= hd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_height_reg <= h_next;
        s2_top_reg    <= top_val[ROW_W-1:0];
        s2_bottom_reg <= bot_val[ROW_W-1:0];
        s2_info_reg   <= hd_tag;
    end

    // Step divider: (texture_height << 16) / height; rows ride in the tag.
    localparam int STAG_W = INFO_W + HEIGHT_W + 2 * ROW_W;
    logic              sd_valid;
    logic [SNUM_W-1:0] sd_quo;
    logic [STAG_W-1:0] sd_tag;

    wcp_divider #(
        .NUM_W(SNUM_W),
        .DEN_W(HEIGHT_W),
        .TAG_W(STAG_W)
    ) u_step_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s2_valid_reg),
        .numerator  ({s2_info_reg.texture_height, 16'd0}),
        .denominator(s2_height_reg),
        .in_tag     ({s2_info_reg, s2_height_reg, s2_top_reg, s2_bottom_reg}),
        .out_valid  (sd_valid),
        .quotient   (sd_quo),
        .out_tag    (sd_tag)
    );

    side_info_t          sd_info;
    logic [HEIGHT_W-1:0] sd_height;
    logic [ROW_W-1:0]    sd_top;
    logic [ROW_W-1:0]    sd_bottom;
    assign {sd_info, sd_height, sd_top, sd_bottom} = sd_tag;

    // Stage 3: saturate the step and register the overhang.
    logic                s3_valid_reg;
    logic [Q26_W-1:0]    s3_step_reg;
    logic [HEIGHT_W-1:0] s3_over_reg;
    logic [HEIGHT_W-1:0] s3_height_reg;
    logic [ROW_W-1:0]    s3_top_reg;
    logic [ROW_W-1:0]    s3_bottom_reg;
    side_info_t          s3_info_reg;

    logic [Q26_W-1:0]    step_next;
    logic [HEIGHT_W-1:0] over_next;

    always_comb
    begin
        // Quotient is at most 27 bits; saturate into Q10.16.
        step_next = (sd_quo > SNUM_W'(Q26_MAX)) ? Q26_MAX : sd_quo[Q26_W-1:0];
        over_next = ({{(HEIGHT_W-RW){1'b0}}, ROWS} < sd_height)
                    ? sd_height - HEIGHT_W'(ROWS) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= sd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_step_reg   <= step_next;
        s3_over_reg   <= over_next;
        s3_height_reg <= sd_height;
        s3_top_reg    <= sd_top;
        s3_bottom_reg <= sd_bottom;
        s3_info_reg   <= sd_info;
    end

    // Stage 4: overhang times step (19 x 26), halve, saturate.
    logic                   s4_valid_reg;
    logic [Q26_W-1:0]       s4_start_reg;
    logic [Q26_W-1:0]       s4_step_reg;
    logic [HEIGHT_W-1:0]    s4_height_reg;
    logic [ROW_W-1:0]       s4_top_reg;
    logic [ROW_W-1:0]       s4_bottom_reg;
    side_info_t             s4_info_reg;

    logic [HEIGHT_W+Q26_W-1:0] start_prod;
    logic [HEIGHT_W+Q26_W-1:0] start_half;
    logic [Q26_W-1:0]          start_next;

    always_comb
    begin
        start_prod = {{Q26_W{1'b0}}, s3_over_reg} * {{HEIGHT_W{1'b0}}, s3_step_reg};
        start_half = start_prod >> 1;
        start_next = (start_half > (HEIGHT_W+Q26_W)'(Q26_MAX)) ? Q26_MAX
                     : start_half[Q26_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_start_reg  <= start_next;
        s4_step_reg   <= s3_step_reg;
        s4_height_reg <= s3_height_reg;
        s4_top_reg    <= s3_top_reg;
        s4_bottom_reg <= s3_bottom_reg;
        s4_info_reg   <= s3_info_reg;
    end

    assign done         = s4_valid_reg;
    assign wall_height  = s4_height_reg;
    assign top_row      = s4_top_reg;
    assign bottom_row   = s4_bottom_reg;
    assign wall_face    = s4_info_reg.wall_face;
    assign texel_column = s4_info_reg.texel_column;
    assign row_step     = s4_step_reg;
    assign row_start    = s4_start_reg;

    `WCP_ASSERT_NEXT(a_start_enters, clk, rst_n, start, s1_valid_reg)
    `WCP_ASSERT_IMP(a_height_nonzero, clk, rst_n, done, wall_height != '0)
    `WCP_ASSERT_IMP(a_rows_ordered, clk, rst_n, done, top_row <= bottom_row)
    `WCP_ASSERT_NEXT(a_valid_advance, clk, rst_n, s3_valid_reg, done)

endmodule

// ===== bench/wall_column_projection_tb.sv =====
// Self-checking bench for the wall column projection block.
`timescale 1ns / 1ps
module wall_column_projection_tb;
    import wcp_pkg::*;

    localparam int SCREEN_ROWS = 1024;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 190;

    // Direction codes without a name in the package.
    localparam logic [1:0] SIGN_ZERO   = 2'd0;
    localparam logic [1:0] SIGN_UNUSED = 2'd3;
    // Register index that maps to no register.
    localparam logic [1:0] REG_NONE    = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0] wall_dist;
        logic [FRAC_W-1:0] frac;
        logic              side;
        logic [1:0]        sx;
        logic [1:0]        sy;
    } column_req_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [ROW_W-1:0]    top;
        logic [ROW_W-1:0]    bottom;
        logic [1:0]          face;
        logic [COL_W-1:0]    col;
        logic [Q26_W-1:0]    step;
        logic [Q26_W-1:0]    start;
    } projection_t;

    // Keeps the register copy, predicts each column and checks results in order.
    class projection_scoreboard;
        logic [DIST_W-1:0] near_limit;
        logic [TEX_W-1:0]  tex_width;
        logic [TEX_W-1:0]  tex_height;
        projection_t       pending[$];
        int                mismatches;
        int                checked;

        function void reset_regs();
            near_limit = 24'd6554;
            tex_width  = 11'd64;
            tex_height = 11'd64;
        endfunction

        function void write_reg(logic [1:0] idx, logic [DIST_W-1:0] val);
            if (idx == REG_NEAR_LIMIT)
                near_limit = val;
            else if (idx == REG_TEXTURE_WIDTH)
                tex_width = val[TEX_W-1:0];
            else if (idx == REG_TEXTURE_HEIGHT)
                tex_height = val[TEX_W-1:0];
        endfunction

        function void note_request(column_req_t r);
            logic [63:0] d, h, half, top, bot, col, step, st;
            logic        mirror;
            projection_t p;
            d = 64'(r.wall_dist);
            if (d < 64'(near_limit))
                d = 64'(near_limit);
            if (d == 0)
                d = 1;
            h = (64'(SCREEN_ROWS) << 16) / d;
            if (h < 1)
                h = 1;
            if (h > 64'(HEIGHT_MAX))
                h = 64'(HEIGHT_MAX);
            half = h / 2;
            top  = (half >= SCREEN_ROWS / 2) ? 64'd0 : SCREEN_ROWS / 2 - half;
            bot  = SCREEN_ROWS / 2 + half;
            if (bot > SCREEN_ROWS - 1)
                bot = SCREEN_ROWS - 1;
            if (!r.side)
                p.face = (r.sx == SIGN_NEG) ? FACE_EAST : FACE_WEST;
            else
                p.face = (r.sy == SIGN_NEG) ? FACE_SOUTH : FACE_NORTH;
            mirror = (!r.side && r.sx == SIGN_POS) || (r.side && r.sy == SIGN_NEG);
            if (tex_width == 0)
                col = 0;
            else
            begin
                col = (64'(r.frac) * 64'(tex_width)) >> 16;
                if (mirror)
                    col = 64'(tex_width) - 1 - col;
                if (col > 64'(tex_width) - 1)
                    col = 64'(tex_width) - 1;
                if (col > 64'(COL_MAX))
                    col = 64'(COL_MAX);
            end
            step = (64'(tex_height) << 16) / h;
            if (step > 64'(Q26_MAX))
                step = 64'(Q26_MAX);
            st = 0;
            if (h > SCREEN_ROWS)
                st = ((h - SCREEN_ROWS) * step) / 2;
            if (st > 64'(Q26_MAX))
                st = 64'(Q26_MAX);
            p.height = h[HEIGHT_W-1:0];
            p.top    = top[ROW_W-1:0];
            p.bottom = bot[ROW_W-1:0];
            p.col    = col[COL_W-1:0];
            p.step   = step[Q26_W-1:0];
            p.start  = st[Q26_W-1:0];
            pending.push_back(p);
        endfunction

        function void check_result(projection_t got);
            projection_t want;
            logic        bad;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            bad = (got.height != want.height) || (got.top != want.top)
                || (got.bottom != want.bottom) || (got.face != want.face)
                || (got.col != want.col) || (got.step != want.step)
                || (got.start != want.start);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: column %0d expected %p got %p", checked, want, got);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [DIST_W-1:0] wall_distance;
    logic [FRAC_W-1:0] hit_fraction;
    logic              hit_side;
    logic [1:0]        dir_x_sign;
    logic [1:0]        dir_y_sign;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [DIST_W-1:0] cfg_data;
    logic              done;
    projection_t       result;

    projection_scoreboard column_board;
    int  stall_cycles;
    int  sent;
    bit  gaps_on;

    wall_column_projection #(.SCREEN_ROWS(SCREEN_ROWS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .wall_distance(wall_distance),
        .hit_fraction (hit_fraction),
        .hit_side     (hit_side),
        .dir_x_sign   (dir_x_sign),
        .dir_y_sign   (dir_y_sign),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .wall_height  (result.height),
        .top_row      (result.top),
        .bottom_row   (result.bottom),
        .wall_face    (result.face),
        .texel_column (result.col),
        .row_step     (result.step),
        .row_start    (result.start)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Note each accepted request and check each result on the edge that takes it;
    // both sample values from before the edge, so the order within the step is moot.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            column_board.note_request({wall_distance, hit_fraction, hit_side,
                                       dir_x_sign, dir_y_sign});
        if (rst_n && done)
            column_board.check_result(result);
    end

    // Watchdog: end the run after a long stretch with no request and no result.
    initial
    begin
        stall_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((start && !busy) || done || !rst_n)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Present one request and hold it until the block takes it; start stays high
    // so back-to-back requests need no second assignment in the same step.
    task automatic send_column(column_req_t r);
        start         <= 1'b1;
        wall_distance <= r.wall_dist;
        hit_fraction  <= r.frac;
        hit_side      <= r.side;
        dir_x_sign    <= r.sx;
        dir_y_sign    <= r.sy;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        // Drop start for a burst of idle cycles now and then.
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Write one register; only called while nothing is in flight.
    task automatic write_reg(logic [1:0] idx, logic [DIST_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        column_board.write_reg(idx, val);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Lower start and wait until every predicted column has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (column_board.pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic column_req_t random_column(logic [DIST_W-1:0] near);
        column_req_t r;
        int          mode;
        mode = $urandom_range(0, 9);
        // Spread distances over every magnitude, with some close to the near limit.
        if (mode < 6)
            r.wall_dist = DIST_W'($urandom >> $urandom_range(8, 31));
        else if (mode < 8)
            r.wall_dist = near + DIST_W'($urandom_range(0, 4)) - DIST_W'(2);
        else
            r.wall_dist = DIST_W'($urandom);
        r.frac = FRAC_W'($urandom);
        r.side = 1'($urandom);
        r.sx   = 2'($urandom);
        r.sy   = 2'($urandom);
        return r;
    endfunction

    task automatic random_phase(int count);
        repeat (count) send_column(random_column(column_board.near_limit));
    endtask

    initial
    begin
        column_board = new();
        column_board.reset_regs();
        column_board.mismatches = 0;
        column_board.checked = 0;
        sent          = 0;
        gaps_on       = 1'b1;
        rst_n         = 1'b0;
        start         = 1'b0;
        wall_distance = '0;
        hit_fraction  = '0;
        hit_side      = 1'b0;
        dir_x_sign    = SIGN_ZERO;
        dir_y_sign    = SIGN_ZERO;
        cfg_we        = 1'b0;
        cfg_index     = REG_NEAR_LIMIT;
        cfg_data      = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed columns at the reset settings: distance and fraction extremes,
        // every face and mirror case, the unused direction code.
        send_column({24'd0,       16'h0000, 1'b0, SIGN_NEG,    SIGN_ZERO});
        send_column({24'd1,       16'hFFFF, 1'b0, SIGN_POS,    SIGN_ZERO});
        send_column({24'd6553,    16'h8000, 1'b0, SIGN_ZERO,   SIGN_POS});
        send_column({24'd6554,    16'h0001, 1'b0, SIGN_UNUSED, SIGN_NEG});
        send_column({24'd65536,   16'hFFFF, 1'b1, SIGN_POS,    SIGN_NEG});
        send_column({24'd65536,   16'h0000, 1'b1, SIGN_NEG,    SIGN_POS});
        send_column({24'd131072,  16'h4000, 1'b1, SIGN_ZERO,   SIGN_ZERO});
        send_column({24'd131072,  16'hC000, 1'b1, SIGN_ZERO,   SIGN_UNUSED});
        send_column({24'hFFFFFF,  16'hFFFF, 1'b0, SIGN_NEG,    SIGN_NEG});
        send_column({24'h800000,  16'h1234, 1'b1, SIGN_POS,    SIGN_POS});
        send_column({24'd32768,   16'hFFFF, 1'b0, SIGN_POS,    SIGN_POS});
        random_phase(PHASE_ITEMS);
        drain();

        // Smallest legal near limit and largest legal texture size.
        write_reg(REG_NEAR_LIMIT, 24'd256);
        write_reg(REG_TEXTURE_WIDTH, 24'd1024);
        write_reg(REG_TEXTURE_HEIGHT, 24'd1024);
        send_column({24'd0,   16'hFFFF, 1'b0, SIGN_POS, SIGN_ZERO});
        send_column({24'd255, 16'h0000, 1'b1, SIGN_ZERO, SIGN_NEG});
        random_phase(PHASE_ITEMS);
        drain();

        // Zero near limit with zero distance, zero texture width and height.
        write_reg(REG_NEAR_LIMIT, 24'd0);
        write_reg(REG_TEXTURE_WIDTH, 24'd0);
        write_reg(REG_TEXTURE_HEIGHT, 24'd0);
        send_column({24'd0, 16'hFFFF, 1'b0, SIGN_POS, SIGN_NEG});
        send_column({24'd0, 16'h0000, 1'b1, SIGN_NEG, SIGN_NEG});
        send_column({24'd1, 16'h8000, 1'b1, SIGN_POS, SIGN_POS});
        random_phase(PHASE_ITEMS);
        drain();

        // Farthest near limit and one-texel textures.
        write_reg(REG_NEAR_LIMIT, 24'hFFFFFF);
        write_reg(REG_TEXTURE_WIDTH, 24'd1);
        write_reg(REG_TEXTURE_HEIGHT, 24'd1);
        random_phase(PHASE_ITEMS);
        drain();

        // Widest texture values the registers hold; an unmapped index is ignored.
        write_reg(REG_NEAR_LIMIT, 24'd0);
        write_reg(REG_TEXTURE_WIDTH, 24'd2047);
        write_reg(REG_TEXTURE_HEIGHT, 24'd2047);
        write_reg(REG_NONE, 24'hABCDEF);
        random_phase(PHASE_ITEMS);
        drain();

        // Random settings.
        write_reg(REG_NEAR_LIMIT,
                  DIST_W'($urandom_range(256, 24'hFFFFFF) >> $urandom_range(0, 15)));
        write_reg(REG_TEXTURE_WIDTH, DIST_W'($urandom_range(1, 1024)));
        write_reg(REG_TEXTURE_HEIGHT, DIST_W'($urandom_range(1, 1024)));
        random_phase(PHASE_ITEMS);
        drain();

        // Back to the reset settings and run flat out with no gaps.
        write_reg(REG_NEAR_LIMIT, 24'd6554);
        write_reg(REG_TEXTURE_WIDTH, 24'd64);
        write_reg(REG_TEXTURE_HEIGHT, 24'd64);
        gaps_on = 1'b0;
        random_phase(PHASE_ITEMS);
        drain();
        repeat (100) @(posedge clk);

        $display("Sent %0d columns over seven register settings; %0d results checked.",
                 sent, column_board.checked);
        $display("Mismatches: %0d", column_board.mismatches);
        if (column_board.mismatches == 0 && column_board.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wcp_pkg.sv
rtl/wcp_divider.sv
rtl/wall_column_projection.sv
bench/wall_column_projection_tb.sv
